/* src/assert_macros.svh */
// assertion macros for the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define R0S_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define R0S_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/r0s_pkg.sv */
// shared constants for the raid0 stripe request splitter
// no dependencies; imported by every module of the block
package r0s_pkg;

    localparam int OPCODE_W      = 1;
    localparam int LOFF_W        = 48;
    localparam int LEN_W         = 18;
    localparam int IDX_W         = 4;
    localparam int MOFF_W        = 48;
    localparam int SS_W          = 31;
    localparam int MC_W          = 5;
    localparam int REM_W         = 32;
    localparam int ALU_W         = 48;
    localparam int CHUNK_CNT_W   = 6;
    localparam int RESULT_CAP    = 64;

    localparam int MAX_MEMBERS_DEF = 16;
    localparam int OFFSET_BITS_DEF = 48;

    localparam logic [LEN_W-1:0] MAX_LEN    = 18'd258048;
    localparam logic [SS_W-1:0]  STRIPE_MIN = 31'd4096;
    localparam logic [SS_W-1:0]  STRIPE_MAX = 31'd1073741824;
    localparam logic [SS_W-1:0]  SS_RESET   = 31'd65536;
    localparam logic [MC_W-1:0]  MC_RESET   = 5'd1;

    // configuration register indexes
    localparam logic REG_STRIPE_SIZE  = 1'b0;
    localparam logic REG_MEMBER_COUNT = 1'b1;

endpackage

/* src/r0s_addsub.sv */
// shared add/subtract unit with carry out, used for divide and multiply steps
// depends on r0s_pkg
module r0s_addsub import r0s_pkg::*; #(
    parameter int W = ALU_W
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W-1:0] sum,
    output logic         carry
);

    logic [W-1:0] b_op;
    logic [W:0]   total;

    assign b_op  = sub ? ~b : b;
    // with sub set, carry high means a >= b
    assign total = {1'b0, a} + {1'b0, b_op} + {{W{1'b0}}, sub};
    assign sum   = total[W-1:0];
    assign carry = total[W];

endmodule

/* src/raid0_stripe_request_splitter_top.sv */
// raid0 stripe request splitter: maps one logical request onto member chunks
// depends on r0s_pkg and r0s_addsub
//
// channel   | handshake            | payload
// ----------+----------------------+-----------------------------------------------
// request   | start, busy          | opcode, logical_offset, request_length
// result    | result_valid strobe  | member_index, member_offset, chunk_length,
//           |                      | chunk_kind, error, last
// config    | cfg_we               | cfg_index, cfg_data
//
// a request is taken when start is high and busy is low
// setup runs on the shared add/subtract unit: a
//   bit-serial divide by stripe size, a bit-serial divide by member count and
//   a shift-add multiply of the row number by stripe size
// then one chunk per cycle; if the offset wraps past 2^OFFSET_BITS the setup
//   runs once more for the wrapped offset
// zero-length and over-length requests never raise busy; the error result
//   shows in the cycle after the accept
// rst_n is asynchronous, active low; results are strobes for one cycle and
//   cannot be stalled
module raid0_stripe_request_splitter_top import r0s_pkg::*; #(
    parameter int MAX_MEMBERS = MAX_MEMBERS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // request side
    input  logic                start,
    output logic                busy,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [LOFF_W-1:0]   logical_offset,
    input  logic [LEN_W-1:0]    request_length,
    // result side
    output logic                result_valid,
    output logic [IDX_W-1:0]    member_index,
    output logic [MOFF_W-1:0]   member_offset,
    output logic [LEN_W-1:0]    chunk_length,
    output logic                chunk_kind,
    output logic                error,
    output logic                last,
    // configuration
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [SS_W-1:0]     cfg_data
);

    localparam int OB     = OFFSET_BITS;
    localparam int STEPS  = (OB > MOFF_W) ? OB : MOFF_W;
    localparam int STEP_W = $clog2(STEPS);

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIV_SS = 5'b00010,   // offset / stripe size
        S_DIV_MC = 5'b00100,   // stripe / member count
        S_MUL    = 5'b01000,   // row * stripe size
        S_EMIT   = 5'b10000    // one chunk per cycle
    } state_t;

    state_t state_reg, state_next;

    // configuration, stored already clamped
    logic [SS_W-1:0] ss_reg;
    logic [MC_W-1:0] mc_reg;

    // control
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [CHUNK_CNT_W-1:0] chunk_cnt_reg, chunk_cnt_next;
    logic                   result_valid_reg, result_valid_next;

    // datapath
    logic [OB-1:0]     off_reg, off_next;
    logic [OB-1:0]     dq_reg, dq_next;          // dividend out / quotient in, multiplier
    logic [REM_W-1:0]  rem_part_reg, rem_part_next;
    logic [MOFF_W-1:0] acc_reg, acc_next;        // product, then row base on the member
    logic [MOFF_W-1:0] mcand_reg, mcand_next;
    logic [SS_W-1:0]   inside_reg, inside_next;
    logic [SS_W-1:0]   room_reg, room_next;
    logic [MC_W-1:0]   idx_reg, idx_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic              kind_reg, kind_next;

    // output payload
    logic [IDX_W-1:0]  member_index_reg, member_index_next;
    logic [MOFF_W-1:0] member_offset_reg, member_offset_next;
    logic [LEN_W-1:0]  chunk_length_reg, chunk_length_next;
    logic              chunk_kind_reg, chunk_kind_next;
    logic              error_reg, error_next;
    logic              last_reg, last_next;

    // shared unit
    logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
    logic             alu_sub, alu_carry;

    // divide step helpers
    logic [REM_W-1:0] partial;
    logic [REM_W-1:0] divisor;

    // chunk helpers
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  rem_left;
    logic [OB:0]       off_sum;
    logic [MOFF_W-1:0] moff;
    logic              accept;
    logic              row_wrap;

    assign accept = start && (state_reg == S_IDLE);

    r0s_addsub #(.W(ALU_W)) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // restoring divide: bring down the next dividend bit
    assign partial = {rem_part_reg[REM_W-2:0], dq_reg[OB-1]};
    assign divisor = (state_reg == S_DIV_MC) ? REM_W'(mc_reg) : REM_W'(ss_reg);

    always_comb
    begin
        if (state_reg == S_MUL)
        begin
            alu_a   = acc_reg;
            alu_b   = dq_reg[0] ? mcand_reg : '0;
            alu_sub = 1'b0;
        end
        else
        begin
            alu_a   = ALU_W'(partial);
            alu_b   = ALU_W'(divisor);
            alu_sub = 1'b1;
        end
    end

    // chunk arithmetic
    assign len      = ({{(SS_W-LEN_W){1'b0}}, rem_reg} < room_reg) ? rem_reg
                                                                   : room_reg[LEN_W-1:0];
    assign rem_left = rem_reg - len;
    assign off_sum  = {1'b0, off_reg} + (OB+1)'(len);
    assign moff     = acc_reg + MOFF_W'(inside_reg);
    assign row_wrap = (idx_reg + MC_W'(1)) == mc_reg;

    always_comb
    begin
        state_next         = state_reg;
        step_next          = step_reg;
        chunk_cnt_next     = chunk_cnt_reg;
        result_valid_next  = 1'b0;
        off_next           = off_reg;
        dq_next            = dq_reg;
        rem_part_next      = rem_part_reg;
        acc_next           = acc_reg;
        mcand_next         = mcand_reg;
        inside_next        = inside_reg;
        room_next          = room_reg;
        idx_next           = idx_reg;
        rem_next           = rem_reg;
        kind_next          = kind_reg;
        member_index_next  = member_index_reg;
        member_offset_next = member_offset_reg;
        chunk_length_next  = chunk_length_reg;
        chunk_kind_next    = chunk_kind_reg;
        error_next         = error_reg;
        last_next          = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (request_length > MAX_LEN)
                    begin
                        // over-length request: single error result
                        result_valid_next  = 1'b1;
                        member_index_next  = '0;
                        member_offset_next = '0;
                        chunk_length_next  = '0;
                        chunk_kind_next    = opcode[0];
                        error_next         = 1'b1;
                        last_next          = 1'b1;
                    end
                    else if (request_length != '0)
                    begin
                        off_next       = OB'(logical_offset);
                        dq_next        = OB'(logical_offset);
                        rem_part_next  = '0;
                        rem_next       = request_length;
                        kind_next      = opcode[0];
                        chunk_cnt_next = '0;
                        step_next      = STEP_W'(OB-1);
                        state_next     = S_DIV_SS;
                    end
                end
            end
            S_DIV_SS:
            begin
                rem_part_next = alu_carry ? alu_sum[REM_W-1:0] : partial;
                dq_next       = {dq_reg[OB-2:0], alu_carry};
                step_next     = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    // quotient is the stripe number, remainder the offset inside it
                    inside_next   = rem_part_next[SS_W-1:0];
                    rem_part_next = '0;
                    step_next     = STEP_W'(OB-1);
                    state_next    = S_DIV_MC;
                end
            end
            S_DIV_MC:
            begin
                room_next     = ss_reg - inside_reg;
                rem_part_next = alu_carry ? alu_sum[REM_W-1:0] : partial;
                dq_next       = {dq_reg[OB-2:0], alu_carry};
                step_next     = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    // quotient is the row on the member, remainder the member
                    idx_next   = rem_part_next[MC_W-1:0];
                    acc_next   = '0;
                    mcand_next = MOFF_W'(ss_reg);
                    step_next  = STEP_W'(MOFF_W-1);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next   = alu_sum[MOFF_W-1:0];
                mcand_next = {mcand_reg[MOFF_W-2:0], 1'b0};
                dq_next    = {1'b0, dq_reg[OB-1:1]};
                step_next  = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                result_valid_next  = 1'b1;
                member_index_next  = idx_reg[IDX_W-1:0];
                member_offset_next = moff;
                chunk_length_next  = len;
                chunk_kind_next    = kind_reg;
                error_next         = 1'b0;
                last_next          = (rem_left == '0);

                rem_next       = rem_left;
                off_next       = off_sum[OB-1:0];
                inside_next    = '0;
                room_next      = ss_reg;
                chunk_cnt_next = chunk_cnt_reg + CHUNK_CNT_W'(1);
                if (row_wrap)
                begin
                    idx_next = '0;
                    acc_next = acc_reg + MOFF_W'(ss_reg);
                end
                else
                begin
                    idx_next = idx_reg + MC_W'(1);
                end

                priority if (rem_left == '0 || chunk_cnt_reg == CHUNK_CNT_W'(RESULT_CAP-1))
                begin
                    state_next = S_IDLE;
                end
                else if (off_sum[OB])
                begin
                    // offset wrapped: redo the mapping for the wrapped offset
                    dq_next       = off_sum[OB-1:0];
                    rem_part_next = '0;
                    step_next     = STEP_W'(OB-1);
                    state_next    = S_DIV_SS;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= '0;
            chunk_cnt_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            chunk_cnt_reg    <= chunk_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // configuration registers, clamped to the supported range on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ss_reg <= SS_RESET;
            mc_reg <= MC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STRIPE_SIZE:
                begin
                    if (cfg_data < STRIPE_MIN)
                        ss_reg <= STRIPE_MIN;
                    else if (cfg_data > STRIPE_MAX)
                        ss_reg <= STRIPE_MAX;
                    else
                        ss_reg <= cfg_data;
                end
                REG_MEMBER_COUNT:
                begin
                    if (cfg_data[MC_W-1:0] == '0)
                        mc_reg <= MC_W'(1);
                    else if (32'(cfg_data[MC_W-1:0]) > MAX_MEMBERS)
                        mc_reg <= MC_W'(MAX_MEMBERS);
                    else
                        mc_reg <= cfg_data[MC_W-1:0];
                end
                default:
                begin
                    ss_reg <= ss_reg;
                end
            endcase
        end
    end

    // datapath and output payload, no reset needed
    always_ff @(posedge clk)
    begin
        off_reg           <= off_next;
        dq_reg            <= dq_next;
        rem_part_reg      <= rem_part_next;
        acc_reg           <= acc_next;
        mcand_reg         <= mcand_next;
        inside_reg        <= inside_next;
        room_reg          <= room_next;
        idx_reg           <= idx_next;
        rem_reg           <= rem_next;
        kind_reg          <= kind_next;
        member_index_reg  <= member_index_next;
        member_offset_reg <= member_offset_next;
        chunk_length_reg  <= chunk_length_next;
        chunk_kind_reg    <= chunk_kind_next;
        error_reg         <= error_next;
        last_reg          <= last_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = result_valid_reg;
    assign member_index  = member_index_reg;
    assign member_offset = member_offset_reg;
    assign chunk_length  = chunk_length_reg;
    assign chunk_kind    = chunk_kind_reg;
    assign error         = error_reg;
    assign last          = last_reg;

endmodule

/* src/r0s_checker.sv */
// port-level checks for the raid0 stripe request splitter, bound to the top level
// depends on r0s_pkg and assert_macros.svh
`include "assert_macros.svh"

module r0s_checker import r0s_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic [LEN_W-1:0]    request_length,
    input logic                result_valid,
    input logic [IDX_W-1:0]    member_index,
    input logic [MOFF_W-1:0]   member_offset,
    input logic [LEN_W-1:0]    chunk_length,
    input logic                error,
    input logic                last
);

    // a normal request keeps the block busy after it is taken
    `R0S_ASSERT_NEXT(a_busy_after_start, start && !busy && request_length != '0 && request_length <= MAX_LEN, busy, "request taken but block not busy")

    // an empty request gives nothing and leaves the block free
    `R0S_ASSERT_NEXT(a_empty_request, start && !busy && request_length == '0, !result_valid && !busy, "empty request produced activity")

    // error result is a lone, zeroed, final result
    `R0S_ASSERT_NOW(a_error_shape, result_valid && error, last && chunk_length == '0 && member_index == '0 && member_offset == '0, "malformed error result")

    // every normal chunk carries bytes, and the block is free once the last one shows
    `R0S_ASSERT_NOW(a_chunk_nonzero, result_valid && !error, chunk_length != '0 && chunk_length <= MAX_LEN, "bad chunk length")
    `R0S_ASSERT_NOW(a_free_on_last, result_valid && last, !busy, "busy after final result")

endmodule

bind raid0_stripe_request_splitter_top r0s_checker u_r0s_checker (.*);

/* tb/sv/tb.sv */
// self-checking bench for raid0_stripe_request_splitter_top: drives requests, predicts
// the member chunks of each one and checks every result strobe in order
// depends on r0s_pkg and the splitter rtl
module tb import r0s_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // run limits
    localparam int CYCLE_LIMIT   = 1000000;
    // two full setups plus a full burst of chunks, with margin
    localparam int SETTLE_CYCLES = 400;
    localparam int PRINT_CAP     = 60;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 38;

    localparam longint unsigned OFF_MASK = (64'd1 << OFFSET_BITS_DEF) - 64'd1;
    localparam logic [LEN_W-1:0] LEN_ALL = {LEN_W{1'b1}};

    typedef enum logic [OPCODE_W-1:0] {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    // one expected chunk, laid out like the result ports
    typedef struct packed {
        logic [IDX_W-1:0]  member_index;
        logic [MOFF_W-1:0] member_offset;
        logic [LEN_W-1:0]  chunk_length;
        logic              chunk_kind;
        logic              error;
        logic              last;
    } chunk_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OPCODE_W-1:0] opcode = '0;
    logic [LOFF_W-1:0]   logical_offset = '0;
    logic [LEN_W-1:0]    request_length = '0;
    logic                result_valid;
    logic [IDX_W-1:0]    member_index;
    logic [MOFF_W-1:0]   member_offset;
    logic [LEN_W-1:0]    chunk_length;
    logic                chunk_kind;
    logic                error;
    logic                last;
    logic                cfg_we = 1'b0;
    logic                cfg_index = 1'b0;
    logic [SS_W-1:0]     cfg_data = '0;

    // bench copy of the two geometry registers
    logic [SS_W-1:0] stripe_bytes = SS_RESET;
    logic [MC_W-1:0] member_total = MC_RESET;

    // chunks predicted but not yet seen on the result ports
    chunk_t pending_chunks[$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    // when set, the sender adds no random gap between requests
    bit  no_gaps = 1'b0;

    raid0_stripe_request_splitter_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .logical_offset (logical_offset),
        .request_length (request_length),
        .result_valid   (result_valid),
        .member_index   (member_index),
        .member_offset  (member_offset),
        .chunk_length   (chunk_length),
        .chunk_kind     (chunk_kind),
        .error          (error),
        .last           (last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // one line per mismatch, printing stops after a cap but counting goes on
    task automatic flag_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // stripe size as the block uses it, pulled into the legal range
    function automatic longint unsigned eff_stripe();
        if (stripe_bytes < STRIPE_MIN)
            return STRIPE_MIN;
        if (stripe_bytes > STRIPE_MAX)
            return STRIPE_MAX;
        return stripe_bytes;
    endfunction

    // predicts the chunks of one accepted request and queues them
    function automatic void split_request(input logic [OPCODE_W-1:0] kind,
                                          input logic [LOFF_W-1:0] loff,
                                          input logic [LEN_W-1:0] len);
        longint unsigned ss;
        longint unsigned mc;
        longint unsigned off;
        longint unsigned rem;
        longint unsigned stripe;
        longint unsigned in_stripe;
        longint unsigned room;
        longint unsigned clen;
        longint unsigned row_base;
        int n;
        chunk_t c;
        ss = eff_stripe();
        mc = member_total;
        // zero members act as one, too many act as the maximum
        if (mc < 1)
            mc = 1;
        if (mc > MAX_MEMBERS_DEF)
            mc = MAX_MEMBERS_DEF;
        // zero length: nothing comes out
        if (len == '0)
            return;
        // over-length: a single error chunk with zeroed address fields
        if (len > MAX_LEN)
        begin
            c = '0;
            c.chunk_kind = kind;
            c.error = 1'b1;
            c.last = 1'b1;
            pending_chunks.push_back(c);
            return;
        end
        off = loff & OFF_MASK;
        rem = len;
        n = 0;
        while (rem != 0 && n < RESULT_CAP)
        begin
            stripe = off / ss;
            in_stripe = off % ss;
            room = ss - in_stripe;
            clen = (rem < room) ? rem : room;
            rem = rem - clen;
            row_base = (stripe / mc) * ss;
            c.member_index = IDX_W'(stripe % mc);
            c.member_offset = MOFF_W'(row_base + in_stripe);
            c.chunk_length = LEN_W'(clen);
            c.chunk_kind = kind;
            c.error = 1'b0;
            c.last = (rem == 0);
            pending_chunks.push_back(c);
            n++;
            // offset wraps at the top of the logical space
            off = (off + clen) & OFF_MASK;
        end
    endfunction

    // scoreboard: predict on every accepted request, then check the strobe of this
    // cycle, so every chunk, the error chunk included, already has its expectation
    always @(posedge clk)
    begin
        chunk_t want;
        if (rst_n)
        begin
            if (start && busy === 1'b0)
                split_request(opcode, logical_offset, request_length);
            if (result_valid !== 1'b0)
            begin
                if (pending_chunks.size() == 0)
                    flag_mismatch($sformatf("unexpected result, member %0d offset 0x%0h len %0d",
                                            member_index, member_offset, chunk_length));
                else
                begin
                    want = pending_chunks.pop_front();
                    if (member_index !== want.member_index)
                        flag_mismatch($sformatf("member_index got %0d want %0d",
                                                member_index, want.member_index));
                    if (member_offset !== want.member_offset)
                        flag_mismatch($sformatf("member_offset got 0x%0h want 0x%0h",
                                                member_offset, want.member_offset));
                    if (chunk_length !== want.chunk_length)
                        flag_mismatch($sformatf("chunk_length got %0d want %0d",
                                                chunk_length, want.chunk_length));
                    if (chunk_kind !== want.chunk_kind)
                        flag_mismatch($sformatf("chunk_kind got %b want %b",
                                                chunk_kind, want.chunk_kind));
                    if (error !== want.error)
                        flag_mismatch($sformatf("error got %b want %b", error, want.error));
                    if (last !== want.last)
                        flag_mismatch($sformatf("last got %b want %b", last, want.last));
                end
            end
        end
    end

    // sends one request; hold_off first waits until every expected chunk is back
    task automatic send_request(input op_t kind, input longint unsigned off,
                                input logic [LEN_W-1:0] len, input bit hold_off);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (hold_off || gap != 0)
        begin
            start <= 1'b0;
            if (hold_off)
            begin
                @(posedge clk);
                while (pending_chunks.size() != 0)
                    @(posedge clk);
            end
            repeat (gap) @(posedge clk);
        end
        // start stays high straight into the next request when there is no gap
        start <= 1'b1;
        opcode <= kind;
        logical_offset <= LOFF_W'(off);
        request_length <= len;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // lets the block go idle: all chunks back, then room for a trailing setup
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_chunks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes both geometry registers back to back, only while idle
    task automatic set_geometry(input logic [SS_W-1:0] ss, input logic [MC_W-1:0] mc);
        cfg_we <= 1'b1;
        cfg_index <= REG_STRIPE_SIZE;
        cfg_data <= ss;
        @(posedge clk);
        cfg_index <= REG_MEMBER_COUNT;
        cfg_data <= SS_W'(mc);
        @(posedge clk);
        cfg_we <= 1'b0;
        stripe_bytes = ss;
        member_total = mc;
    endtask

    // reset geometry: 64 KiB stripes on a single member
    task automatic test_reset_geometry();
        send_request(OP_READ, 0, 1, 1'b0);
        send_request(OP_WRITE, 65535, 2, 1'b0);
        send_request(OP_READ, 0, 0, 1'b0);
    endtask

    // smallest stripe, most members: longest bursts, length limits, offset wrap
    task automatic test_smallest_stripe();
        settle();
        set_geometry(STRIPE_MIN, 5'd16);
        send_request(OP_WRITE, 0, MAX_LEN, 1'b0);
        // unaligned start touches one more stripe: the full 64 chunks
        send_request(OP_READ, 100, MAX_LEN, 1'b0);
        send_request(OP_READ, 0, LEN_W'(MAX_LEN + 1), 1'b0);
        send_request(OP_WRITE, OFF_MASK, LEN_ALL, 1'b0);
        send_request(OP_WRITE, OFF_MASK - 1, 10000, 1'b0);
        send_request(OP_READ, OFF_MASK, 1, 1'b0);
        send_request(OP_WRITE, 4095, 4097, 1'b0);
    endtask

    // register values outside the legal range are pulled in by the block
    task automatic test_clamped_geometry();
        settle();
        set_geometry('0, '0);
        send_request(OP_READ, 5000, 9000, 1'b0);
        send_request(OP_WRITE, 12345, 0, 1'b0);
        settle();
        set_geometry({SS_W{1'b1}}, {MC_W{1'b1}});
        send_request(OP_READ, (64'd1 << 30) - 5, 100, 1'b0);
        send_request(OP_WRITE, OFF_MASK - 999, MAX_LEN, 1'b0);
        send_request(OP_READ, 47 * (64'd1 << 30) + 7, 3, 1'b0);
    endtask

    // a stripe size that is not a power of two, and the largest legal stripe
    task automatic test_odd_stripe();
        settle();
        set_geometry(SS_W'(STRIPE_MIN + 1), 5'd3);
        send_request(OP_WRITE, 0, 20000, 1'b0);
        send_request(OP_READ, (64'd1 << 47) + 1, 50000, 1'b0);
        send_request(OP_READ, OFF_MASK - 2999, 9000, 1'b0);
        settle();
        set_geometry(STRIPE_MAX, 5'd1);
        send_request(OP_WRITE, OFF_MASK, MAX_LEN, 1'b0);
        send_request(OP_READ, (64'd1 << 30) - 1, 2, 1'b0);
    endtask

    // random geometry per phase, then mostly well-formed requests with random
    // offsets and lengths, plus zero-length and over-length noise
    task automatic test_random_traffic();
        logic [SS_W-1:0] ss;
        logic [MC_W-1:0] mc;
        longint unsigned off;
        longint unsigned stride;
        logic [LEN_W-1:0] len;
        int pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            case ($urandom_range(0, 5))
                0: ss = STRIPE_MIN;
                1: ss = STRIPE_MAX;
                2: ss = SS_W'(64'd1 << $urandom_range(12, 30));
                3: ss = SS_W'($urandom_range(4096, 200000));
                4: ss = SS_W'($urandom);
                default: ss = SS_W'($urandom_range(0, 4095));
            endcase
            mc = ($urandom_range(0, 3) == 0) ? MC_W'($urandom) : MC_W'($urandom_range(1, 16));
            set_geometry(ss, mc);
            // one phase runs with no random gaps between requests
            no_gaps = (phase == 2);
            stride = eff_stripe();
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    len = '0;
                else if (pick < 9)
                    len = LEN_W'($urandom_range(MAX_LEN + 1, LEN_ALL));
                else if (pick < 40)
                    len = LEN_W'($urandom_range(1, 4096));
                else if (pick < 75)
                    len = LEN_W'($urandom_range(1, MAX_LEN));
                else
                    len = LEN_W'($urandom_range(MAX_LEN - 8192, MAX_LEN));
                off = {$urandom, $urandom} & OFF_MASK;
                pick = $urandom_range(0, 99);
                if (pick >= 55 && pick < 75)
                    // just short of a stripe boundary
                    off = ((off / stride) * stride - $urandom_range(0, 64)) & OFF_MASK;
                else if (pick >= 75 && pick < 90)
                    // near the top of the logical space, so the burst can wrap
                    off = (OFF_MASK + 1 - $urandom_range(1, 300000)) & OFF_MASK;
                else if (pick >= 90)
                    off = $urandom_range(0, 1 << 20);
                send_request(op_t'($urandom_range(0, 1)), off, len,
                             $urandom_range(0, 15) == 0);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_geometry();
        test_smallest_stripe();
        test_clamped_geometry();
        test_odd_stripe();
        test_random_traffic();
        settle();
        if (pending_chunks.size() != 0)
            flag_mismatch($sformatf("%0d expected chunks never came", pending_chunks.size()));
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
